// ===== sv/lwrr_pkg.sv =====
package lwrr_pkg;

    // Sizing
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CFG_W     = 5;
    localparam int REQ_W     = 4;
    localparam int OP_W      = 2;
    localparam int STS_W     = 3;
    localparam int CNT_MIN_W = $clog2(MAX_PROCS + 1);
    localparam int CNT_W     = (CFG_W > CNT_MIN_W) ? CFG_W : CNT_MIN_W;

    localparam logic [CFG_W-1:0] CFG_RST = CFG_W'(16);

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOCK    = 2'd0;
    localparam logic [OP_W-1:0] OP_TRYLOCK = 2'd1;
    localparam logic [OP_W-1:0] OP_UNLOCK  = 2'd2;

    typedef enum logic [STS_W-1:0] {
        STS_GRANTED  = 3'd0,
        STS_WAIT     = 3'd1,
        STS_BUSY     = 3'd2,
        STS_RELEASED = 3'd3,
        STS_REJECTED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status          status;
        logic             handoff_valid;
        logic [REQ_W-1:0] handoff_target;
    } t_result;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] next;
    } t_scan_res;

    typedef struct packed {
        logic    ready;
        logic    done;
        t_result result;
    } t_seq_out;

endpackage

// ===== sv/lwrr_if.sv =====
interface lwrr_req_if;
    import lwrr_pkg::*;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [REQ_W-1:0] requester;

    modport source (output valid, output operation, output requester, input ready);
    modport sink   (input valid, input operation, input requester, output ready);
endinterface

interface lwrr_rsp_if;
    import lwrr_pkg::*;
    logic             valid;
    logic             ready;
    logic [STS_W-1:0] status;
    logic             handoff_valid;
    logic [REQ_W-1:0] handoff_target;

    modport source (output valid, output status, output handoff_valid,
                    output handoff_target, input ready);
    modport sink   (input valid, input status, input handoff_valid,
                    input handoff_target, output ready);
endinterface

interface lwrr_cfg_if;
    import lwrr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lwrr_scan.sv =====
module lwrr_scan import lwrr_pkg::*; (
    input  logic [MAX_PROCS-1:0] i_waitlist,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [CNT_W-1:0]     i_count,
    output t_scan_res            o_res
);

    logic [CNT_W-1:0] w_inc;

    // test one bit, advance the index with wrap at the count
    assign w_inc          = CNT_W'(i_idx) + CNT_W'(1);
    assign o_res.hit      = i_waitlist[i_idx];
    assign o_res.next     = (w_inc >= i_count) ? '0 : w_inc[IDX_W-1:0];

endmodule

// ===== sv/lwrr_seq.sv =====
module lwrr_seq import lwrr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [OP_W-1:0]      i_op,
    input  logic [REQ_W-1:0]     i_req,
    input  logic [CNT_W-1:0]     i_count,
    input  logic                 i_out_free,
    input  t_scan_res            i_scan,
    output logic [IDX_W-1:0]     o_scan_idx,
    output logic [MAX_PROCS-1:0] o_waitlist,
    output t_seq_out             o_seq
);

    t_state                r_state, n_state;
    logic [MAX_PROCS-1:0]  r_wl;
    logic [OP_W-1:0]       r_op;
    logic [IDX_W-1:0]      r_bit_idx;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_left;
    logic                  r_found;
    logic [IDX_W-1:0]      r_target;
    logic                  r_rej;

    logic [CNT_W-1:0]      w_req_cnt;
    logic [IDX_W-1:0]      w_req_idx;
    logic                  w_rej;
    logic                  w_emit;

    assign w_req_cnt  = CNT_W'(i_req);
    assign w_req_idx  = w_req_cnt[IDX_W-1:0];
    assign w_rej      = (w_req_cnt >= i_count) ||
                        !((i_op == OP_LOCK) || (i_op == OP_TRYLOCK) || (i_op == OP_UNLOCK));
    assign w_emit     = (r_state == S_DONE) && i_out_free;
    assign o_scan_idx = (r_state == S_IDLE) ? w_req_idx : r_idx;
    assign o_waitlist = r_wl;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = w_rej ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_left == '0) || i_scan.hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_seq.ready                 = (r_state == S_IDLE);
        o_seq.done                  = w_emit;
        o_seq.result.status         = STS_REJECTED;
        o_seq.result.handoff_valid  = 1'b0;
        o_seq.result.handoff_target = '0;
        if (!r_rej) begin
            priority case (r_op)
                OP_LOCK:    o_seq.result.status = r_found ? STS_WAIT : STS_GRANTED;
                OP_TRYLOCK: o_seq.result.status = r_found ? STS_BUSY : STS_GRANTED;
                OP_UNLOCK: begin
                    o_seq.result.status        = STS_RELEASED;
                    o_seq.result.handoff_valid = r_found;
                    if (r_found) begin
                        o_seq.result.handoff_target = REQ_W'(CNT_W'(r_target));
                    end
                end
                default: o_seq.result.status = STS_REJECTED;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wl    <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE) && i_start && !w_rej) begin
                r_wl[w_req_idx] <= (i_op != OP_UNLOCK);
            end
            // failed trylock drops its bit again
            if (w_emit && !r_rej && (r_op == OP_TRYLOCK) && r_found) begin
                r_wl[r_bit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_op      <= i_op;
                    r_rej     <= w_rej;
                    r_bit_idx <= w_req_idx;
                    r_idx     <= i_scan.next;
                    r_left    <= i_count - CNT_W'(1);
                    r_found   <= 1'b0;
                    r_target  <= '0;
                end
            end
            S_SCAN: begin
                if (r_left != '0) begin
                    if (i_scan.hit) begin
                        r_found  <= 1'b1;
                        r_target <= r_idx;
                    end else begin
                        r_idx  <= i_scan.next;
                        r_left <= r_left - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/lock_waitlist_round_robin_handoff.sv =====
// Round-robin lock manager. Each request word carries an operation (lock,
// trylock, unlock) and a requester id; each one returns exactly one response
// word with a status and, for an unlock, the participant that now owns the
// lock. A request is handled in steps (count = participant count in use,
// 1..16): the word is taken and its waitlist bit updated, then a single
// bit-test-and-advance unit walks the other count-1 waitlist bits round-robin
// from requester+1 and closes the walk, and then the response is posted (it
// waits while the output register still holds a stalled response). Rejected
// ids and codes skip the walk. The walk stops early on the first waiting
// participant. A posted response sits in an output register, so the next
// request is taken while it waits. The user must write the participant count
// on the config channel only while the block is idle; the block itself does
// not enforce this. The participant count resets to 16.
module lock_waitlist_round_robin_handoff import lwrr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lwrr_cfg_if.sink    i_cfg,
    lwrr_req_if.sink    i_req,
    lwrr_rsp_if.source  o_rsp
);

    logic [CFG_W-1:0]     r_num_procs;
    logic                 r_out_vld;
    t_result              r_out;

    logic [CNT_W-1:0]     w_cfg_cnt;
    logic [CNT_W-1:0]     w_count;
    logic                 w_out_free;
    logic                 w_start;
    logic [IDX_W-1:0]     w_scan_idx;
    logic [MAX_PROCS-1:0] w_waitlist;
    t_scan_res            w_scan;
    t_seq_out             w_seq;

    // Config register: always ready, hold the last written count.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_procs <= CFG_RST;
        end else if (i_cfg.valid) begin
            r_num_procs <= i_cfg.data;
        end
    end

    // Clamp the count: zero acts as one, anything above the maximum as the maximum.
    assign w_cfg_cnt = CNT_W'(r_num_procs);

    always_comb begin
        priority if (w_cfg_cnt == '0) begin
            w_count = CNT_W'(1);
        end else if (w_cfg_cnt > CNT_W'(MAX_PROCS)) begin
            w_count = CNT_W'(MAX_PROCS);
        end else begin
            w_count = w_cfg_cnt;
        end
    end

    // Request side: ready only while the sequencer is idle.
    assign i_req.ready = w_seq.ready;
    assign w_start     = i_req.valid && w_seq.ready;

    // The output register frees up when empty or when its word is taken.
    assign w_out_free  = !r_out_vld || o_rsp.ready;

    lwrr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_op       (i_req.operation),
        .i_req      (i_req.requester),
        .i_count    (w_count),
        .i_out_free (w_out_free),
        .i_scan     (w_scan),
        .o_scan_idx (w_scan_idx),
        .o_waitlist (w_waitlist),
        .o_seq      (w_seq)
    );

    // Shared unit: tests one waitlist bit and computes the wrapped next index.
    lwrr_scan u_scan (
        .i_waitlist (w_waitlist),
        .i_idx      (w_scan_idx),
        .i_count    (w_count),
        .o_res      (w_scan)
    );

    // Response register: load on a finished request, drop on handoff.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_seq.done) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq.done) begin
            r_out <= w_seq.result;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.handoff_valid  = r_out.handoff_valid;
    assign o_rsp.handoff_target = r_out.handoff_target;

endmodule

// ===== sv/lwrr_chk.sv =====
module lwrr_chk import lwrr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [STS_W-1:0] i_status,
    input logic             i_hv,
    input logic [REQ_W-1:0] i_ht
);

    // a stalled response holds its word
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status) &&
        $stable(i_hv) && $stable(i_ht))
        else $error("response changed while stalled");

    a_sts_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_status <= STS_REJECTED)
        else $error("status code out of range");

    a_hv_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_hv |-> i_status == STS_RELEASED)
        else $error("handoff outside an unlock");

    a_ht_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_hv |-> i_ht == '0)
        else $error("handoff target set without handoff");

    // one request at a time: busy right after taking a word
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while a request is in flight");

endmodule

bind lock_waitlist_round_robin_handoff lwrr_chk u_lwrr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_hv        (o_rsp.handoff_valid),
    .i_ht        (o_rsp.handoff_target)
);

// ===== tb/tb.sv =====
module tb;
    import lwrr_pkg::*;

    // Encoding left unused by the block; it must come back as a rejection.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 1500;
    // Cycles with no handshake on any channel before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Drain time once the last response is in: one full scan plus margin.
    localparam int DRAIN_CYCLES = 2 * MAX_PROCS + 8;

    typedef struct {
        bit               is_cfg;
        logic [OP_W-1:0]  op;
        logic [REQ_W-1:0] who;
        logic [CFG_W-1:0] count;
    } t_word;

    typedef enum {FLOW, COIN, SPARSE, PATTERN} t_stall_mode;

    logic clk;
    logic rst_n;

    lwrr_cfg_if cfg ();
    lwrr_req_if req ();
    lwrr_rsp_if rsp ();

    lock_waitlist_round_robin_handoff DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Stimulus waiting to be driven, and responses the lock model says are due.
    t_word   words[$];
    t_result results_due[$];

    // Shadow of the block's state: waitlist bitmap and participant count register.
    logic [MAX_PROCS-1:0] waitlist_model = '0;
    logic [CFG_W-1:0]     count_reg      = CFG_RST;

    int errors      = 0;
    int idle_cycles = 0;

    // Sender burst/gap bookkeeping, owned by the driver.
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall pattern, owned by the monitor.
    t_stall_mode stall_mode = FLOW;
    int          stall_left = 0;
    logic [7:0]  stall_pat  = 8'hff;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Clamp the register value to the participant count actually in force:
    // zero behaves as one, anything above MAX_PROCS as MAX_PROCS.
    function automatic int live_count(input logic [CFG_W-1:0] value);
        if (value == '0)
            return 1;
        if (int'(value) > MAX_PROCS)
            return MAX_PROCS;
        return int'(value);
    endfunction

    // Apply one request word to the waitlist shadow and return the response
    // the block owes for it.
    function automatic t_result lock_outcome(input logic [OP_W-1:0]  op,
                                             input logic [REQ_W-1:0] who);
        int                   n;
        int                   probe;
        int                   i;
        logic [MAX_PROCS-1:0] in_use;
        logic [MAX_PROCS-1:0] own;
        t_result              r;
        n = live_count(count_reg);
        r.status         = STS_REJECTED;
        r.handoff_valid  = 1'b0;
        r.handoff_target = '0;
        // Out-of-range ids and the unused code leave the waitlist alone.
        if (int'(who) < n && op != OP_UNUSED) begin
            own = '0;
            own[who] = 1'b1;
            in_use = '0;
            for (i = 0; i < n; i++)
                in_use[i] = 1'b1;
            if (op == OP_UNLOCK) begin
                waitlist_model &= ~own;
                r.status = STS_RELEASED;
                // Walk round-robin from the next id, wrapping at the live count;
                // bits at or above the count are never visited.
                probe = (int'(who) + 1 >= n) ? 0 : int'(who) + 1;
                for (i = 0; i < n && !r.handoff_valid; i++) begin
                    if (waitlist_model[probe]) begin
                        r.handoff_valid  = 1'b1;
                        r.handoff_target = REQ_W'(probe);
                    end else begin
                        probe = (probe + 1 >= n) ? 0 : probe + 1;
                    end
                end
            end else begin
                waitlist_model |= own;
                if ((waitlist_model & in_use & ~own) == '0) begin
                    r.status = STS_GRANTED;
                end else if (op == OP_LOCK) begin
                    r.status = STS_WAIT;
                end else begin
                    // A failed trylock withdraws its bit.
                    r.status = STS_BUSY;
                    waitlist_model &= ~own;
                end
            end
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        if (errors < 100)
            $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic push_req(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] who);
        t_word w;
        w.is_cfg = 1'b0;
        w.op     = op;
        w.who    = who;
        w.count  = '0;
        words.push_back(w);
    endtask

    task automatic push_cfg(input logic [CFG_W-1:0] value);
        t_word w;
        w.is_cfg = 1'b1;
        w.op     = OP_LOCK;
        w.who    = '0;
        w.count  = value;
        words.push_back(w);
    endtask

    // Driver: hold a word until it is taken, then move on to the next one or
    // sit out a gap. A register write waits until every response is back.
    always @(posedge clk) begin : drive
        t_word w;
        logic  next_req_valid;
        logic  next_cfg_valid;
        if (!rst_n) begin
            req.valid <= 1'b0;
            cfg.valid <= 1'b0;
        end else begin
            next_req_valid = req.valid;
            next_cfg_valid = cfg.valid;
            if (req.valid && req.ready) begin
                results_due.push_back(lock_outcome(req.operation, req.requester));
                next_req_valid = 1'b0;
            end
            if (cfg.valid && cfg.ready) begin
                count_reg      = cfg.data;
                next_cfg_valid = 1'b0;
            end
            if (!next_req_valid && !next_cfg_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (words.size() != 0) begin
                    w = words[0];
                    if (w.is_cfg) begin
                        // A response taken at this edge is still counted as
                        // outstanding, whichever block the simulator runs first.
                        if (results_due.size() == 0 && !(rsp.valid && rsp.ready)) begin
                            cfg.data       <= w.count;
                            next_cfg_valid = 1'b1;
                            void'(words.pop_front());
                        end
                    end else begin
                        req.operation  <= w.op;
                        req.requester  <= w.who;
                        next_req_valid = 1'b1;
                        void'(words.pop_front());
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
                        end
                    end
                end
            end
            req.valid <= next_req_valid;
            cfg.valid <= next_cfg_valid;
        end
    end

    // Monitor: check each response word against the oldest prediction and
    // stall the response channel on a randomly chosen pattern that is redrawn
    // whenever its current run ends.
    always @(posedge clk) begin : observe
        t_result exp_r;
        logic    next_ready;
        if (!rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("response word with no request outstanding");
                end else begin
                    exp_r = results_due.pop_front();
                    if (rsp.status !== exp_r.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                rsp.status, exp_r.status));
                    if (rsp.handoff_valid !== exp_r.handoff_valid)
                        flag_mismatch($sformatf("handoff_valid got %0b want %0b",
                                                rsp.handoff_valid, exp_r.handoff_valid));
                    if (rsp.handoff_target !== exp_r.handoff_target)
                        flag_mismatch($sformatf("handoff_target got %0d want %0d",
                                                rsp.handoff_target, exp_r.handoff_target));
                end
            end
            if (stall_left <= 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(100, 300);
                stall_pat  = 8'($urandom_range(1, 255));
            end
            stall_left--;
            stall_pat = {stall_pat[0], stall_pat[7:1]};
            case (stall_mode)
                FLOW:    next_ready = 1'b1;
                COIN:    next_ready = $urandom_range(0, 1);
                SPARSE:  next_ready = ($urandom_range(0, 3) == 0);
                default: next_ready = stall_pat[0];
            endcase
            rsp.ready <= next_ready;
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req.valid && req.ready) || (cfg.valid && cfg.ready) ||
                (rsp.valid && rsp.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          made;
        int          phase_len;
        int          n;
        int          pick;
        logic [CFG_W-1:0] value;
        logic [OP_W-1:0]  op;
        logic [REQ_W-1:0] who;

        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.operation = OP_LOCK;
        req.requester = '0;
        cfg.valid     = 1'b0;
        cfg.data      = CFG_RST;
        rsp.ready     = 1'b0;

        // Directed part at the reset count of 16: grant, wait, busy trylock,
        // handoffs in order, relock by the holder, unlock by a non-holder.
        push_req(OP_LOCK, 4'd0);
        push_req(OP_LOCK, 4'd5);
        push_req(OP_TRYLOCK, 4'd9);
        push_req(OP_LOCK, 4'd15);
        push_req(OP_UNLOCK, 4'd0);
        push_req(OP_UNLOCK, 4'd5);
        push_req(OP_UNLOCK, 4'd15);
        push_req(OP_TRYLOCK, 4'd3);
        push_req(OP_TRYLOCK, 4'd3);
        push_req(OP_UNLOCK, 4'd7);
        push_req(OP_UNLOCK, 4'd3);
        push_req(OP_UNUSED, 4'd15);
        push_req(OP_UNUSED, 4'd0);
        // A count of zero behaves as one participant.
        push_cfg(5'd0);
        push_req(OP_LOCK, 4'd0);
        push_req(OP_LOCK, 4'd1);
        push_req(OP_TRYLOCK, 4'd15);
        push_req(OP_UNLOCK, 4'd0);
        // Oversized count behaves as 16; unlock at the top id wraps to zero.
        push_cfg(5'd31);
        push_req(OP_LOCK, 4'd12);
        push_req(OP_LOCK, 4'd15);
        push_req(OP_LOCK, 4'd14);
        push_req(OP_UNLOCK, 4'd15);
        push_req(OP_UNLOCK, 4'd14);
        // Shrink the count with bit 12 still set: it must be ignored.
        push_cfg(5'd4);
        push_req(OP_LOCK, 4'd2);
        push_req(OP_LOCK, 4'd3);
        push_req(OP_UNLOCK, 4'd2);
        push_req(OP_UNLOCK, 4'd3);
        push_req(OP_LOCK, 4'd12);

        // Random part: phases at assorted counts, mostly in-range traffic.
        made = 0;
        while (made < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       value = 5'd1;
                1:       value = 5'd2;
                2:       value = 5'd16;
                3:       value = 5'd0;
                4:       value = 5'd31;
                5:       value = 5'd17;
                default: value = CFG_W'($urandom_range(3, 15));
            endcase
            push_cfg(value);
            n = live_count(value);
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    op = OP_LOCK;
                else if (pick < 55)
                    op = OP_TRYLOCK;
                else if (pick < 95)
                    op = OP_UNLOCK;
                else
                    op = OP_UNUSED;
                if ($urandom_range(0, 9) == 0)
                    who = REQ_W'($urandom_range(0, 15));
                else
                    who = REQ_W'($urandom_range(0, n - 1));
                push_req(op, who);
                made++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: sample at the falling edge so queue and valid updates of the
        // rising edge have settled.
        while (words.size() != 0 || req.valid || cfg.valid || results_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
